// ----- rtl/strc_pkg.sv -----
package strc_pkg;

    localparam int STICK_W = 16;
    localparam int MAG_W = 16;
    localparam int OUT_W = 17;
    localparam int MAXR_W = 11;
    localparam int CURVE_W = 16;
    localparam int E_W = 17;
    localparam int SUP_A_W = 24;
    localparam int NUM_W = 33;
    localparam int DEN_W = 22;
    localparam int K_W = 25;
    localparam int REM_W = 58;
    localparam int Q_W = 16;
    localparam int DIV_STEPS = 16;
    localparam int CONV_SHIFT = 20;
    localparam int LIM_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RATE_LIMIT_DEF = 1998;

    localparam logic [K_W-1:0] DEG_TO_Q10 = 25'd18740330;
    localparam logic [DEN_W-1:0] SUPER_ONE = 22'd3276800;
    localparam logic [DEN_W-1:0] SUPER_FLOOR = 22'd32768;
    localparam logic [SUP_A_W-1:0] SUPER_KNEE = 24'd3244032;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_MAXR_ROLL,
        CFG_MAXR_PITCH,
        CFG_MAXR_YAW,
        CFG_CURVE_ROLL,
        CFG_CURVE_PITCH,
        CFG_CURVE_YAW
    } cfg_idx_t;

    typedef struct packed {
        logic sat;
        logic neg;
    } div_ctl_t;

    function automatic logic [OUT_W-1:0] sat_code(input int limit);
        longint unsigned v;
        v = (longint'(limit) * 64'd18740330 + 64'd524288) >> CONV_SHIFT;
        return v[OUT_W-1:0];
    endfunction

endpackage

// ----- rtl/strc_div_step.sv -----
module strc_div_step #(
    parameter int SHIFT = 0
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [strc_pkg::REM_W-1:0]        rem_in,
    input  logic [strc_pkg::DEN_W-1:0]        den_in,
    input  logic [strc_pkg::Q_W-1:0]          q_in,
    input  strc_pkg::div_ctl_t                ctl_in,
    output logic [strc_pkg::REM_W-1:0]        rem_out,
    output logic [strc_pkg::DEN_W-1:0]        den_out,
    output logic [strc_pkg::Q_W-1:0]          q_out,
    output strc_pkg::div_ctl_t                ctl_out
);

    logic [strc_pkg::REM_W-1:0] dsh;
    logic                       take;

    assign dsh  = strc_pkg::REM_W'(den_in) << (strc_pkg::CONV_SHIFT + SHIFT);
    assign take = rem_in >= dsh;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out <= take ? rem_in - dsh : rem_in;
            q_out   <= q_in | (strc_pkg::Q_W'(take) << SHIFT);
            den_out <= den_in;
            ctl_out <= ctl_in;
        end
    end

endmodule

// ----- rtl/strc_lane.sv -----
module strc_lane #(
    parameter int RATE_LIMIT_DPS = strc_pkg::RATE_LIMIT_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [strc_pkg::STICK_W-1:0]      stick,
    input  logic                              curve_mode,
    input  logic [strc_pkg::MAXR_W-1:0]       full_rate,
    input  logic [strc_pkg::CURVE_W-1:0]      curve,
    output logic [strc_pkg::OUT_W-1:0]        rate
);

    localparam logic [strc_pkg::LIM_W-1:0] LIM = strc_pkg::LIM_W'(RATE_LIMIT_DPS);
    localparam logic [strc_pkg::OUT_W-1:0] QSAT = strc_pkg::sat_code(RATE_LIMIT_DPS);
    localparam int N = strc_pkg::DIV_STEPS;

    logic [strc_pkg::E_W-1:0]     e_reg, e_next;
    logic [7:0]                   rc, sup;

    logic [strc_pkg::MAG_W-1:0]   mag_a_reg;
    logic                         neg_a_reg;

    logic [strc_pkg::NUM_W-1:0]   num_b_reg;
    logic [strc_pkg::SUP_A_W-1:0] a_b_reg;
    logic                         neg_b_reg;
    logic [strc_pkg::NUM_W-1:0]   pe;

    logic [strc_pkg::NUM_W-1:0]   num_c_reg;
    logic [strc_pkg::DEN_W-1:0]   den_c_reg, den_c_next;
    logic                         neg_c_reg;

    logic [41:0]                  ph_d_reg;
    logic [40:0]                  pl_d_reg;
    logic [strc_pkg::DEN_W-1:0]   den_d_reg;
    strc_pkg::div_ctl_t           ctl_d_reg;

    logic [strc_pkg::REM_W-1:0]   rem_s [0:N];
    logic [strc_pkg::DEN_W-1:0]   den_s [0:N];
    logic [strc_pkg::Q_W-1:0]     q_s   [0:N];
    strc_pkg::div_ctl_t           ctl_s [0:N];

    logic [strc_pkg::OUT_W-1:0]   qf;

    assign rc  = curve[7:0];
    assign sup = curve[15:8];

    always_comb begin
        e_next = strc_pkg::E_W'(rc) * strc_pkg::E_W'(100);
        if (rc > 8'd200) begin
            e_next = e_next + strc_pkg::E_W'(1454) * strc_pkg::E_W'(rc - 8'd200);
        end
    end

    always_ff @(posedge aclk) begin
        e_reg <= e_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_a_reg <= stick[strc_pkg::STICK_W-1];
            mag_a_reg <= stick[strc_pkg::STICK_W-1] ? (~stick + 1'b1) : stick;
        end
    end

    assign pe = strc_pkg::NUM_W'(e_reg) * strc_pkg::NUM_W'(mag_a_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            num_b_reg <= curve_mode ? {pe[strc_pkg::NUM_W-2:0], 1'b0}
                                    : strc_pkg::NUM_W'(mag_a_reg)
                                      * strc_pkg::NUM_W'(full_rate);
            a_b_reg   <= strc_pkg::SUP_A_W'(mag_a_reg) * strc_pkg::SUP_A_W'(sup);
            neg_b_reg <= neg_a_reg;
        end
    end

    always_comb begin
        priority if (!curve_mode) begin
            den_c_next = strc_pkg::SUPER_FLOOR;
        end else if (a_b_reg >= strc_pkg::SUPER_KNEE) begin
            den_c_next = strc_pkg::SUPER_FLOOR;
        end else begin
            den_c_next = strc_pkg::SUPER_ONE - a_b_reg[strc_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_c_reg <= num_b_reg;
            den_c_reg <= den_c_next;
            neg_c_reg <= neg_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_d_reg      <= 42'(num_c_reg[32:16]) * 42'(strc_pkg::DEG_TO_Q10);
            pl_d_reg      <= 41'(num_c_reg[15:0]) * 41'(strc_pkg::DEG_TO_Q10);
            den_d_reg     <= den_c_reg;
            ctl_d_reg.sat <= num_c_reg >= strc_pkg::NUM_W'(LIM) * strc_pkg::NUM_W'(den_c_reg);
            ctl_d_reg.neg <= neg_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_s[0] <= (strc_pkg::REM_W'(ph_d_reg) << 16) + strc_pkg::REM_W'(pl_d_reg)
                        + (strc_pkg::REM_W'(den_d_reg) << (strc_pkg::CONV_SHIFT - 1));
            den_s[0] <= den_d_reg;
            ctl_s[0] <= ctl_d_reg;
        end
    end

    assign q_s[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_div
        strc_div_step #(.SHIFT(N - 1 - k)) u_step (
            .aclk    (aclk),
            .en      (en),
            .rem_in  (rem_s[k]),
            .den_in  (den_s[k]),
            .q_in    (q_s[k]),
            .ctl_in  (ctl_s[k]),
            .rem_out (rem_s[k+1]),
            .den_out (den_s[k+1]),
            .q_out   (q_s[k+1]),
            .ctl_out (ctl_s[k+1])
        );
    end

    assign qf   = ctl_s[N].sat ? QSAT : strc_pkg::OUT_W'(q_s[N]);
    assign rate = ctl_s[N].neg ? (~qf + 1'b1) : qf;

endmodule

// ----- rtl/stick_to_rate_curve_top.sv -----
// Each input item passes through three axis lanes, each with a 16-step pipelined divider.
// Throughput: one item per cycle while the m_ side is not stalled.
// A result stalled on the m_ side holds the whole pipeline until it is taken.
// Reset (synchronous, aresetn low) clears valid flags and loads the default curve
// registers: super-rate mode, max rates 860/860/500, curves 18020.
module stick_to_rate_curve_top #(
    parameter int RATE_LIMIT_DPS = strc_pkg::RATE_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // stick_roll, stick_pitch, stick_yaw
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // rate_roll, rate_pitch, rate_yaw, pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [strc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [strc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DEPTH = 5 + strc_pkg::DIV_STEPS;
    localparam logic [strc_pkg::OUT_W-1:0] QSAT = strc_pkg::sat_code(RATE_LIMIT_DPS);

    logic                          mode_reg;
    logic [strc_pkg::MAXR_W-1:0]   maxr_reg  [0:2];
    logic [strc_pkg::CURVE_W-1:0]  curve_reg [0:2];
    logic [DEPTH-1:0]              vld_reg;
    logic                          m_tvalid_reg;
    logic [55:0]                   m_tdata_reg;
    logic [strc_pkg::OUT_W-1:0]    rate [0:2];
    logic                          en;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b1;
            maxr_reg[0]  <= 11'd860;
            maxr_reg[1]  <= 11'd860;
            maxr_reg[2]  <= 11'd500;
            curve_reg[0] <= 16'd18020;
            curve_reg[1] <= 16'd18020;
            curve_reg[2] <= 16'd18020;
        end else if (cfg_valid) begin
            case (cfg_index)
                strc_pkg::CFG_MODE:        mode_reg     <= cfg_data[0];
                strc_pkg::CFG_MAXR_ROLL:   maxr_reg[0]  <= cfg_data[10:0];
                strc_pkg::CFG_MAXR_PITCH:  maxr_reg[1]  <= cfg_data[10:0];
                strc_pkg::CFG_MAXR_YAW:    maxr_reg[2]  <= cfg_data[10:0];
                strc_pkg::CFG_CURVE_ROLL:  curve_reg[0] <= cfg_data;
                strc_pkg::CFG_CURVE_PITCH: curve_reg[1] <= cfg_data;
                strc_pkg::CFG_CURVE_YAW:   curve_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        strc_lane #(.RATE_LIMIT_DPS(RATE_LIMIT_DPS)) u_lane (
            .aclk       (aclk),
            .en         (en),
            .stick      (s_tdata[16*i +: 16]),
            .curve_mode (mode_reg),
            .full_rate  (maxr_reg[i]),
            .curve      (curve_reg[i]),
            .rate       (rate[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {5'd0, rate[2], rate[1], rate[0]};
        end
    end

    a_ready_tracks_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_tail_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[DEPTH-1] && en) |=> m_tvalid)
        else $error("pipeline tail item lost");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_roll_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[16:0]) <= $signed({1'b0, QSAT[15:0]})
                   && $signed(m_tdata[16:0]) >= -$signed({1'b0, QSAT[15:0]})))
        else $error("roll rate beyond saturation");

endmodule
